// ===== hdl/jump_confirming_deglitch_filter_defines.svh =====
// ----------------------------------------------------------------------------
// Deglitch filter assertion macros
// Shared assertion forms for the deglitch filter checkers.
// ----------------------------------------------------------------------------
`ifndef JUMP_CONFIRMING_DEGLITCH_FILTER_DEFINES_SVH
`define JUMP_CONFIRMING_DEGLITCH_FILTER_DEFINES_SVH

// Checked only while out of reset.
`define JCDF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define JCDF_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/jcdf_pkg.sv =====
// ----------------------------------------------------------------------------
// jcdf_pkg
// Constants and types of the deglitch filter.
// ----------------------------------------------------------------------------
package jcdf_pkg;

	localparam int CHANNELS = 32;
	localparam int CH_AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	localparam int SAMPLE_W = 32;
	localparam int CHAN_W   = 5;
	localparam int THR_W    = 16;
	localparam int CNT_W    = 4;
	localparam int DATA_W   = 32;
	localparam int PADDR_W  = 4;

	localparam logic [THR_W-1:0] THR_RST     = THR_W'(7);
	localparam logic [CNT_W-1:0] SETTLE_RST  = CNT_W'(5);
	localparam logic [CNT_W-1:0] CONFIRM_RST = CNT_W'(3);
	localparam logic [CNT_W-1:0] CNT_MAX     = '1;

	// register index = paddr[3:2]
	typedef enum logic [1:0] {
		REG_THRESHOLD = 2'd0,
		REG_SETTLE    = 2'd1,
		REG_CONFIRM   = 2'd2
	} reg_idx_t;

	// per-channel filter state, one RAM word
	typedef struct packed {
		logic [SAMPLE_W-1:0] held;
		logic [CNT_W-1:0]    cnt;
		logic                pend;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== hdl/jump_confirming_deglitch_filter.sv =====
// ----------------------------------------------------------------------------
// jump_confirming_deglitch_filter
// Per-channel deglitch filter with a confirmation window for large jumps.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall): one transfer carries a 32-bit sample
//   and a channel number. Output channel (out_valid/out_stall): one transfer
//   per input transfer, carrying the channel's held value after the update.
//   Results leave in input order.
//   out_valid rises once the transfer has passed the read stage and the
//   output register. Throughput is one transfer per cycle while the receiver
//   does not stall, also when the same channel repeats: the state RAM is read
//   at acceptance and written as the item leaves the read stage, and a
//   same-channel read at that write takes the new word from a bypass register.
//   When the receiver stalls, the finished result waits in the output
//   register and one more item can wait in the RAM read stage; only then is
//   in_stall raised.
//   Reset clears the configuration to threshold 7, settle 5, confirm 3 and
//   clears a valid bit per channel; a channel without its valid bit reads as
//   held 0, counter 0, no jump pending. No clearing pass is needed.
//   Configuration (APB, pready always high) must be written only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module jump_confirming_deglitch_filter (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [jcdf_pkg::PADDR_W-1:0]  paddr,
	input  logic [jcdf_pkg::DATA_W-1:0]   pwdata,
	output logic [jcdf_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	// samples in
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [jcdf_pkg::SAMPLE_W-1:0] sample,
	input  logic [jcdf_pkg::CHAN_W-1:0]   channel,
	// results out
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [jcdf_pkg::SAMPLE_W-1:0] filtered
);

	import jcdf_pkg::*;

	// configuration registers
	logic [THR_W-1:0] jump_threshold_q;
	logic [CNT_W-1:0] settle_count_q;
	logic [CNT_W-1:0] confirm_count_q;
	reg_idx_t         reg_idx;
	logic             cfg_wr;

	// handshake
	logic acc;
	logic out_free;
	logic s1_fire;

	// read stage
	logic                s1_v_q;
	logic [SAMPLE_W-1:0] sample_s1;
	logic [CH_AW-1:0]    idx_s1;
	logic                rng_s1;
	logic                vld_s1;
	logic                fwd_s1;
	entry_t              fwd_ent_s1;

	logic [CH_AW-1:0] idx_in;
	logic             rng_in;
	logic [CHANNELS-1:0] valid_q;

	// RAM ports
	logic [ENTRY_W-1:0] rd_data;
	entry_t rd_ent;
	entry_t cur;
	entry_t nxt;
	logic   wr_en;

	// update datapath
	logic [CNT_W-1:0]    settle_m1;
	logic [CNT_W-1:0]    cnt_inc;
	logic [SAMPLE_W-1:0] diff;
	logic                far_jump;

	// output register
	logic                out_valid_q;
	logic [SAMPLE_W-1:0] filtered_q;

	// ---------------- configuration port ----------------
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jump_threshold_q <= THR_RST;
			settle_count_q   <= SETTLE_RST;
			confirm_count_q  <= CONFIRM_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_THRESHOLD: jump_threshold_q <= pwdata[THR_W-1:0];
				REG_SETTLE:    settle_count_q   <= pwdata[CNT_W-1:0];
				REG_CONFIRM:   confirm_count_q  <= pwdata[CNT_W-1:0];
				default: ;  // unmapped: dropped
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_THRESHOLD: prdata = {{(DATA_W-THR_W){1'b0}}, jump_threshold_q};
			REG_SETTLE:    prdata = {{(DATA_W-CNT_W){1'b0}}, settle_count_q};
			REG_CONFIRM:   prdata = {{(DATA_W-CNT_W){1'b0}}, confirm_count_q};
			default:       prdata = '0;
		endcase
	end

	// ---------------- handshake ----------------
	// Output register frees when empty or being taken this cycle; the read
	// stage moves into it then. Input stalls only when the read stage is stuck.
	assign out_free = !out_valid_q || !out_stall;
	assign s1_fire  = s1_v_q && out_free;
	assign in_stall = s1_v_q && !out_free;
	assign acc      = in_valid && !in_stall;

	assign idx_in = channel[CH_AW-1:0];
	assign rng_in = (32'(channel) < CHANNELS);

	// ---------------- state RAM ----------------
	assign wr_en = s1_fire && rng_s1;

	jcdf_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (CHANNELS),
		.AW    (CH_AW)
	) u_state_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (idx_s1),
		.wdata (nxt),
		.re    (acc),
		.raddr (idx_in),
		.rdata (rd_data)
	);

	assign rd_ent = rd_data;

	// per-channel written flags stand in for the all-zero reset of the RAM
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[idx_s1] <= 1'b1;
		end
	end

	// ---------------- read stage ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (acc) begin
			s1_v_q <= 1'b1;
		end else if (s1_fire) begin
			s1_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			sample_s1  <= sample;
			idx_s1     <= idx_in;
			rng_s1     <= rng_in;
			vld_s1     <= valid_q[idx_in];
			// same channel written at this edge: RAM returns the stale word
			fwd_s1     <= wr_en && (idx_s1 == idx_in);
			fwd_ent_s1 <= nxt;
		end
	end

	always_comb begin
		if (fwd_s1) begin
			cur = fwd_ent_s1;
		end else if (vld_s1) begin
			cur = rd_ent;
		end else begin
			cur = '0;
		end
	end

	// ---------------- filter update ----------------
	// settle of zero acts as one
	assign settle_m1 = (settle_count_q == '0) ? '0 : settle_count_q - CNT_W'(1);
	assign cnt_inc   = (cur.cnt == CNT_MAX) ? CNT_MAX : cur.cnt + CNT_W'(1);
	assign diff      = (sample_s1 > cur.held) ? sample_s1 - cur.held
	                                          : cur.held - sample_s1;
	assign far_jump  = diff > {{(SAMPLE_W-THR_W){1'b0}}, jump_threshold_q};

	always_comb begin
		nxt = cur;
		if (!cur.pend) begin
			if (sample_s1 == cur.held) begin
				nxt.cnt = '0;
			end else if (cur.cnt >= settle_m1) begin
				// settled: small change adopted, large one opens the jump window
				if (far_jump) begin
					nxt.pend = 1'b1;
				end else begin
					nxt.held = sample_s1;
				end
				nxt.cnt = '0;
			end else begin
				nxt.cnt = cnt_inc;
			end
		end else begin
			if (far_jump) begin
				nxt.cnt = cnt_inc;
				if (cnt_inc >= confirm_count_q) begin
					nxt.held = sample_s1;
					nxt.cnt  = '0;
					nxt.pend = 1'b0;
				end
			end else begin
				// back in band: jump cancelled
				nxt.cnt  = '0;
				nxt.pend = 1'b0;
			end
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s1_v_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			// out-of-range channel reports zero
			filtered_q <= rng_s1 ? nxt.held : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign filtered  = filtered_q;

endmodule

// ===== hdl/jcdf_ram.sv =====
// ----------------------------------------------------------------------------
// jcdf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module jcdf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// read-before-write; data holds while re is low
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hdl/jcdf_checker.sv =====
// ----------------------------------------------------------------------------
// jcdf_checker
// Port-level assertions for the deglitch filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "jump_confirming_deglitch_filter_defines.svh"

module jcdf_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic pready
);

	// held result stays offered
	`JCDF_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped under stall")

	// no result while in reset
	`JCDF_ASSERT_ALWAYS(a_rst_quiet, !arst_n |-> !out_valid, "out_valid during reset")

	// input backs up only behind a full, stalled output
	`JCDF_ASSERT(a_stall_cause, in_stall |-> out_valid && out_stall && pready,
		"input stalled without output backpressure")

	// a fresh result follows an accepted input transfer
	`JCDF_ASSERT(a_latency, $rose(out_valid) |-> $past(in_valid && !in_stall, 2),
		"result without matching input transfer")

endmodule

bind jump_confirming_deglitch_filter jcdf_checker u_jcdf_checker (.*);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: deglitch filter testbench
// Drives sample transfers with random gaps and output stalls. A predictor
// tracks the per-channel held value, counter and jump flag, and every result
// transfer is checked in order against it. Phases change the thresholds
// through the APB port while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
	import jcdf_pkg::*;

	localparam int DRAIN_CYCLES    = 6;      // pipeline is 2 deep, leave margin
	localparam int HOLD_OFF_CYCLES = 80;     // long output stall, fills the block
	localparam int HOLD_OFF_AT     = 100;    // transfers accepted before it starts

	typedef struct {
		logic [SAMPLE_W-1:0] value;
		logic [CHAN_W-1:0]   chan;
	} sample_item_t;

	// ---------------------------------------------------------------------
	// clock, reset, DUT pins
	// ---------------------------------------------------------------------
	logic                clk      = 1'b0;
	logic                arst_n;
	logic                psel     = 1'b0;
	logic                penable  = 1'b0;
	logic                pwrite   = 1'b0;
	logic [PADDR_W-1:0]  paddr    = '0;
	logic [DATA_W-1:0]   pwdata   = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [SAMPLE_W-1:0] sample   = '0;
	logic [CHAN_W-1:0]   channel  = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [SAMPLE_W-1:0] filtered;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	jump_confirming_deglitch_filter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample    (sample),
		.channel   (channel),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.filtered  (filtered)
	);

	// ---------------------------------------------------------------------
	// predictor state: config mirror plus per-channel filter state
	// ---------------------------------------------------------------------
	logic [THR_W-1:0]    thr_cfg     = THR_RST;
	logic [CNT_W-1:0]    settle_cfg  = SETTLE_RST;
	logic [CNT_W-1:0]    confirm_cfg = CONFIRM_RST;

	logic [SAMPLE_W-1:0] held_mirror  [CHANNELS] = '{default: '0};
	logic [CNT_W-1:0]    count_mirror [CHANNELS] = '{default: '0};
	logic                jump_mirror  [CHANNELS] = '{default: 1'b0};

	sample_item_t        sample_backlog[$];     // waiting to be driven
	logic [SAMPLE_W-1:0] filtered_expected[$];  // predicted, not yet seen
	int unsigned         queued_total   = 0;
	int unsigned         accepted_total = 0;
	int unsigned         fail_count     = 0;

	// idle shaping, changed per phase
	int unsigned         send_gap_max = 0;
	int unsigned         recv_gap_max = 0;
	int unsigned         send_wait    = 0;
	int unsigned         stall_left   = 0;
	logic                hold_off     = 1'b0;

	// stimulus-side guess of each channel's level, only steers the traffic
	logic [SAMPLE_W-1:0] level_guess [CHANNELS] = '{default: '0};

	// ---------------------------------------------------------------------
	// predictor
	// ---------------------------------------------------------------------
	function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] c);
		return (c == CNT_MAX) ? CNT_MAX : c + 1'b1;
	endfunction

	// Applies one sample to the channel state, returns the held value after it.
	function automatic logic [SAMPLE_W-1:0] next_filtered(logic [SAMPLE_W-1:0] smp,
			logic [CHAN_W-1:0] ch);
		int unsigned         settle_eff;
		logic [SAMPLE_W-1:0] delta;
		logic                far_off;

		if (ch >= CHANNELS)
			return '0;    // unused channel: no state touched
		// a zero settle count behaves like one
		settle_eff = (settle_cfg == 0) ? 1 : settle_cfg;
		delta      = (smp > held_mirror[ch]) ? smp - held_mirror[ch] : held_mirror[ch] - smp;
		far_off    = delta > SAMPLE_W'(thr_cfg);

		if (!jump_mirror[ch]) begin
			if (smp == held_mirror[ch]) begin
				count_mirror[ch] = '0;
			end else if (count_mirror[ch] >= settle_eff - 1) begin
				// settled; a counter left above a lowered settle lands here too
				if (far_off)
					jump_mirror[ch] = 1'b1;
				else
					held_mirror[ch] = smp;
				count_mirror[ch] = '0;
			end else begin
				count_mirror[ch] = sat_inc(count_mirror[ch]);
			end
		end else if (far_off) begin
			// jump mode: count out-of-band samples; confirm of zero adopts at once
			count_mirror[ch] = sat_inc(count_mirror[ch]);
			if (count_mirror[ch] >= confirm_cfg) begin
				held_mirror[ch]  = smp;
				count_mirror[ch] = '0;
				jump_mirror[ch]  = 1'b0;
			end
		end else begin
			// back in band: jump dropped
			count_mirror[ch] = '0;
			jump_mirror[ch]  = 1'b0;
		end
		return held_mirror[ch];
	endfunction

	// ---------------------------------------------------------------------
	// driver: one transfer per item from the backlog, random gap before each
	// ---------------------------------------------------------------------
	logic         offer_next;
	sample_item_t next_item;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			sample   <= '0;
			channel  <= '0;
		end else begin
			offer_next = in_valid;
			if (in_valid && !in_stall) begin
				// transfer taken: predict now, state is in acceptance order
				filtered_expected.push_back(next_filtered(sample, channel));
				accepted_total++;
				send_wait  = $urandom_range(0, send_gap_max);
				offer_next = 1'b0;
			end
			if (!offer_next) begin
				if (send_wait > 0) begin
					send_wait--;
				end else if (sample_backlog.size() > 0) begin
					next_item = sample_backlog.pop_front();
					sample   <= next_item.value;
					channel  <= next_item.chan;
					offer_next = 1'b1;
				end
			end
			// single update of valid per edge, payload only moves when not held
			in_valid <= offer_next;
		end
	end

	// ---------------------------------------------------------------------
	// monitor: checks each result transfer, draws the stall after it
	// ---------------------------------------------------------------------
	logic [SAMPLE_W-1:0] want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (filtered_expected.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %h", $time,
						filtered);
					fail_count++;
				end else begin
					want = filtered_expected.pop_front();
					if (filtered !== want) begin
						$display("%0t: filtered mismatch, expected %h, actual %h", $time,
							want, filtered);
						fail_count++;
					end
				end
				stall_left = $urandom_range(0, recv_gap_max);
			end else if (stall_left > 0) begin
				stall_left--;
			end
			out_stall <= hold_off || (stall_left > 0);
		end
	end

	// long receiver hold-off: sender keeps offering, block must back up
	initial begin
		wait (accepted_total >= HOLD_OFF_AT);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_OFF_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	// ---------------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------------
	task automatic push_sample(logic [SAMPLE_W-1:0] value, logic [CHAN_W-1:0] ch, int reps);
		sample_item_t it;
		it.value = value;
		it.chan  = ch;
		repeat (reps) begin
			sample_backlog.push_back(it);
			queued_total++;
		end
	endtask

	// all queued items taken and all results seen, then let the pipe drain
	task automatic wait_idle();
		while (accepted_total != queued_total || filtered_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// APB write: setup, then access; register loads at the access edge
	task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'({idx, 2'b00});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_THRESHOLD: thr_cfg     = value[THR_W-1:0];
			REG_SETTLE:    settle_cfg  = value[CNT_W-1:0];
			REG_CONFIRM:   confirm_cfg = value[CNT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_filter(int unsigned thr, int unsigned settle, int unsigned confirm,
			int unsigned sgap, int unsigned rgap);
		wait_idle();
		write_reg(REG_THRESHOLD, DATA_W'(thr));
		write_reg(REG_SETTLE, DATA_W'(settle));
		write_reg(REG_CONFIRM, DATA_W'(confirm));
		send_gap_max = sgap;
		recv_gap_max = rgap;
	endtask

	// Runs of one value on one channel, 1 to 20 long, some long enough to cross
	// settle and confirm, mixed with in-band steps, far jumps, returns to the held
	// level, extremes and stray noise on any channel.
	task automatic queue_random_traffic(int n_items);
		int                  made;
		int                  run_len;
		int                  kind;
		logic [CHAN_W-1:0]   hot [4];
		logic [CHAN_W-1:0]   ch;
		logic [SAMPLE_W-1:0] level;
		logic [SAMPLE_W-1:0] step;

		made = 0;
		foreach (hot[i])
			hot[i] = CHAN_W'($urandom_range(0, CHANNELS - 1));
		while (made < n_items) begin
			ch   = ($urandom_range(0, 3) == 0) ? CHAN_W'($urandom_range(0, CHANNELS - 1))
			                                   : hot[$urandom_range(0, 3)];
			step = $urandom_range(0, thr_cfg);
			kind = $urandom_range(0, 9);
			case (kind) inside
				[0:2]:   level = $urandom_range(0, 1) ? level_guess[ch] + step
				                                      : level_guess[ch] - step;
				[3:4]:   level = level_guess[ch] + SAMPLE_W'(thr_cfg) + 1 +
				                 $urandom_range(0, 4096);
				5:       level = level_guess[ch] - SAMPLE_W'(thr_cfg) - 1 -
				                 $urandom_range(0, 4096);
				6:       level = level_guess[ch];
				7:       level = $urandom_range(0, 1) ? '1 : '0;
				default: level = $urandom;
			endcase
			run_len = $urandom_range(1, 20);
			for (int k = 0; k < run_len; k++) begin
				if ($urandom_range(0, 11) == 0)
					push_sample($urandom, CHAN_W'($urandom_range(0, CHANNELS - 1)), 1);
				else
					push_sample(level, ch, 1);
				made++;
			end
			if (run_len > 8)
				level_guess[ch] = level;
		end
	endtask

	// ---------------------------------------------------------------------
	// test sequence
	// ---------------------------------------------------------------------
	initial begin
		arst_n <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset thresholds: threshold 7, settle 5, confirm 3
		send_gap_max = 3;
		recv_gap_max = 3;
		push_sample(32'h0000_0000, 5'd0, 1);      // equal to held, counter stays clear
		push_sample(32'h0000_0003, 5'd0, 5);      // small change adopted on the 5th
		push_sample(32'hFFFF_FFFF, 5'd0, 8);      // far jump: 5 to arm, 3 to confirm
		push_sample(32'd1000, 5'd31, 5);          // arms a jump on the top channel
		push_sample(32'd0, 5'd31, 1);             // in-band sample cancels it
		push_sample(32'd50, 5'd5, 4);             // leaves the counter at 4

		// zero settle and confirm, zero threshold; the leftover counter on
		// channel 5 is above the new settle point
		set_filter(0, 0, 0, 2, 2);
		push_sample(32'd50, 5'd5, 1);             // settles at once, arms a jump
		push_sample(32'd60, 5'd5, 1);             // first far sample adopts

		set_filter(16, 2, 2, 0, 0);               // back-to-back, long hold-off lands here
		queue_random_traffic(237);
		set_filter(65535, 15, 15, 7, 7);
		queue_random_traffic(237);
		set_filter(0, 1, 1, 7, 0);
		queue_random_traffic(237);
		set_filter(300, 3, 4, 0, 7);
		queue_random_traffic(237);
		set_filter(1000, 0, 0, 3, 3);
		queue_random_traffic(237);
		set_filter(7, 5, 3, 7, 7);
		queue_random_traffic(237);

		wait_idle();
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// run limit, far above the slowest legal run
	initial begin
		#3_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
